FILE: sv/scd_pkg.sv
package scd_pkg;

    localparam int PIXELS_PER_ROW       = 8;
    localparam int PIXEL_W              = 8;
    localparam int ROW_W                = PIXELS_PER_ROW * PIXEL_W;
    localparam int ROW_SAD_W            = 11;
    localparam int BLOCK_SAD_W          = 14;
    localparam int PERCENT_W            = 7;
    localparam int COUNT_OUT_W          = 18;
    localparam int CFG_INDEX_W          = 2;
    localparam int CFG_DATA_W           = 14;

    localparam int DEF_MAX_FRAME_BLOCKS = 131072;
    localparam int ROW_QUEUE_DEPTH      = 4;
    localparam int RESULT_QUEUE_DEPTH   = 4;

    localparam logic [BLOCK_SAD_W-1:0] BLOCK_SAD_MAX       = 14'd16383;
    localparam logic [BLOCK_SAD_W-1:0] BLOCK_SAD_LIMIT_RST = 14'd320;
    localparam logic [PERCENT_W-1:0]   MOTION_PERCENT_RST  = 7'd85;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SAD_LIMIT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCENE_MOTION_PERCENT = 2'd1;

    typedef struct packed {
        logic [ROW_W-1:0] ref_row;
        logic [ROW_W-1:0] cur_row;
        logic             block_end;
        logic             frame_end;
    } in_item_t;

    typedef struct packed {
        logic                   scene_change;
        logic [COUNT_OUT_W-1:0] motion_blocks;
        logic [COUNT_OUT_W-1:0] frame_blocks;
    } out_item_t;

    typedef struct packed {
        logic [ROW_SAD_W-1:0] row_sad;
        logic                 block_end;
        logic                 frame_end;
    } row_item_t;

    typedef struct packed {
        logic [BLOCK_SAD_W-1:0] block_sad_limit;
        logic [PERCENT_W-1:0]   scene_motion_percent;
    } cfg_regs_t;

endpackage

FILE: sv/scd_fifo.sv
module scd_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

FILE: sv/scd_front.sv
module scd_front
    import scd_pkg::*;
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  in_item_t                             item,
    output logic                                 full,
    input  logic [$clog2(ROW_QUEUE_DEPTH+1)-1:0] q_count,
    output logic                                 q_wr_en,
    output row_item_t                            q_wr_data
);

    localparam int QCNT_W = $clog2(ROW_QUEUE_DEPTH+1);

    logic [PIXEL_W-1:0]  diff_reg [PIXELS_PER_ROW];
    logic [PIXEL_W-1:0]  diff_next [PIXELS_PER_ROW];
    logic                stage_v_reg;
    logic                block_end_reg;
    logic                frame_end_reg;
    logic [QCNT_W:0]     committed;
    logic                accept;
    logic [ROW_SAD_W-1:0] sad_sum;

    assign committed = {1'b0, q_count} + {{QCNT_W{1'b0}}, stage_v_reg};
    assign full      = (committed >= (QCNT_W+1)'(ROW_QUEUE_DEPTH));
    assign accept    = push && !full;

    // per-pixel absolute difference
    always_comb
    begin
        for (int k = 0; k < PIXELS_PER_ROW; k++)
        begin
            if (item.ref_row[k*PIXEL_W +: PIXEL_W] > item.cur_row[k*PIXEL_W +: PIXEL_W])
            begin
                diff_next[k] = item.ref_row[k*PIXEL_W +: PIXEL_W]
                             - item.cur_row[k*PIXEL_W +: PIXEL_W];
            end
            else
            begin
                diff_next[k] = item.cur_row[k*PIXEL_W +: PIXEL_W]
                             - item.ref_row[k*PIXEL_W +: PIXEL_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
        end
        else
        begin
            stage_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg      <= diff_next;
            block_end_reg <= item.block_end;
            frame_end_reg <= item.frame_end;
        end
    end

    always_comb
    begin
        sad_sum = '0;
        for (int k = 0; k < PIXELS_PER_ROW; k++)
        begin
            sad_sum = sad_sum + ROW_SAD_W'(diff_reg[k]);
        end
    end

    assign q_wr_en             = stage_v_reg;
    assign q_wr_data.row_sad   = sad_sum;
    assign q_wr_data.block_end = block_end_reg;
    assign q_wr_data.frame_end = frame_end_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        q_wr_en |-> (q_count < QCNT_W'(ROW_QUEUE_DEPTH)))
    else $error("row queue written while full");

endmodule

FILE: sv/scd_back.sv
module scd_back
    import scd_pkg::*;
#(
    parameter int MAX_FRAME_BLOCKS = DEF_MAX_FRAME_BLOCKS
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cfg_regs_t                               cfg,
    input  logic [$clog2(ROW_QUEUE_DEPTH+1)-1:0]    q_count,
    input  row_item_t                               q_rd_data,
    output logic                                    q_rd_en,
    input  logic [$clog2(RESULT_QUEUE_DEPTH+1)-1:0] out_count,
    output logic                                    out_wr_en,
    output out_item_t                               out_wr_data
);

    localparam int CNT_W  = $clog2(MAX_FRAME_BLOCKS+1);
    localparam int CMP_W  = CNT_W + PERCENT_W + 1;
    localparam int OCNT_W = $clog2(RESULT_QUEUE_DEPTH+1);
    localparam int EXT_W  = CNT_W + COUNT_OUT_W;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v >= CNT_W'(MAX_FRAME_BLOCKS)) ? CNT_W'(MAX_FRAME_BLOCKS) : v + 1'b1;
        return r;
    endfunction

    logic [BLOCK_SAD_W-1:0] block_sad_reg;
    logic [CNT_W-1:0]       motion_reg;
    logic [CNT_W-1:0]       blocks_reg;
    logic                   b_v_reg;
    logic [CNT_W-1:0]       b_motion_reg;
    logic [CNT_W-1:0]       b_blocks_reg;
    logic                   c_v_reg;
    logic [CNT_W-1:0]       c_motion_reg;
    logic [CNT_W-1:0]       c_blocks_reg;
    logic [CMP_W-1:0]       c_prod_reg;
    logic [CMP_W-1:0]       c_lim_reg;

    logic [OCNT_W+1:0]      out_committed;
    logic [BLOCK_SAD_W:0]   sum_ext;
    logic [BLOCK_SAD_W-1:0] sum_sat;
    logic                   close;
    logic [CNT_W-1:0]       motion_inc;
    logic [CNT_W-1:0]       blocks_inc;
    logic [EXT_W-1:0]       motion_ext;
    logic [EXT_W-1:0]       blocks_ext;

    assign out_committed = (OCNT_W+2)'(out_count) + (OCNT_W+2)'(b_v_reg)
                         + (OCNT_W+2)'(c_v_reg);
    assign q_rd_en = (q_count != '0)
                   && (out_committed < (OCNT_W+2)'(RESULT_QUEUE_DEPTH));

    always_comb
    begin
        sum_ext    = {1'b0, block_sad_reg} + (BLOCK_SAD_W+1)'(q_rd_data.row_sad);
        sum_sat    = (sum_ext > {1'b0, BLOCK_SAD_MAX}) ? BLOCK_SAD_MAX
                                                       : sum_ext[BLOCK_SAD_W-1:0];
        close      = q_rd_data.block_end || q_rd_data.frame_end;
        motion_inc = (sum_sat > cfg.block_sad_limit) ? sat_inc(motion_reg) : motion_reg;
        blocks_inc = sat_inc(blocks_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_sad_reg <= '0;
            motion_reg    <= '0;
            blocks_reg    <= '0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
        end
        else
        begin
            b_v_reg <= q_rd_en && q_rd_data.frame_end;
            c_v_reg <= b_v_reg;
            if (q_rd_en)
            begin
                block_sad_reg <= close ? '0 : sum_sat;
                if (q_rd_data.frame_end)
                begin
                    motion_reg <= '0;
                    blocks_reg <= '0;
                end
                else if (close)
                begin
                    motion_reg <= motion_inc;
                    blocks_reg <= blocks_inc;
                end
            end
        end
    end

    // frame totals, then threshold test without a divider:
    // motion >= (p*n+50)/100  <=>  100*motion + 50 > p*n
    always_ff @(posedge clk)
    begin
        if (q_rd_en && q_rd_data.frame_end)
        begin
            b_motion_reg <= motion_inc;
            b_blocks_reg <= blocks_inc;
        end
        if (b_v_reg)
        begin
            c_motion_reg <= b_motion_reg;
            c_blocks_reg <= b_blocks_reg;
            c_prod_reg   <= CMP_W'(cfg.scene_motion_percent) * CMP_W'(b_blocks_reg);
            c_lim_reg    <= CMP_W'(b_motion_reg) * CMP_W'(100) + CMP_W'(50);
        end
    end

    assign motion_ext = {{COUNT_OUT_W{1'b0}}, c_motion_reg};
    assign blocks_ext = {{COUNT_OUT_W{1'b0}}, c_blocks_reg};

    assign out_wr_en                  = c_v_reg;
    assign out_wr_data.scene_change   = (c_lim_reg > c_prod_reg);
    assign out_wr_data.motion_blocks  = motion_ext[COUNT_OUT_W-1:0];
    assign out_wr_data.frame_blocks   = blocks_ext[COUNT_OUT_W-1:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        out_wr_en |-> (out_count < OCNT_W'(RESULT_QUEUE_DEPTH)))
    else $error("result queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_rd_en |-> (q_count != '0))
    else $error("row queue read while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_rd_en && close) |=> (block_sad_reg == '0))
    else $error("block sad not cleared at block close");

    assert property (@(posedge clk) disable iff (!rst_n)
        motion_reg <= blocks_reg)
    else $error("more motion blocks than blocks");

endmodule

FILE: sv/scene_change_sad_detector.sv
// channel   direction  handshake                 payload
// item      in         push / full               in_item_t
// result    out        pop / empty               out_item_t
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one row pair per cycle while full is low; a push is written to the row queue next cycle
// a frame result passes stages b and c once its last row leaves the row queue
// rst_n is asynchronous, active low; it empties queues, zeroes counts, loads cfg defaults
// full rises when the four-entry row queue plus the in-flight row fill it
// rows drain only while the result queue has room for every frame result in flight
module scene_change_sad_detector
    import scd_pkg::*;
#(
    parameter int MAX_FRAME_BLOCKS = DEF_MAX_FRAME_BLOCKS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  in_item_t               item,
    output logic                   empty,
    input  logic                   pop,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int QCNT_W = $clog2(ROW_QUEUE_DEPTH+1);
    localparam int OCNT_W = $clog2(RESULT_QUEUE_DEPTH+1);

    cfg_regs_t        cfg_reg;
    logic [QCNT_W-1:0] q_count;
    logic              q_wr_en;
    row_item_t         q_wr_data;
    logic              q_rd_en;
    row_item_t         q_rd_data;
    logic [OCNT_W-1:0] out_count;
    logic              out_wr_en;
    out_item_t         out_wr_data;
    logic              out_rd_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_sad_limit      <= BLOCK_SAD_LIMIT_RST;
            cfg_reg.scene_motion_percent <= MOTION_PERCENT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLOCK_SAD_LIMIT:
                begin
                    cfg_reg.block_sad_limit <= cfg_data[BLOCK_SAD_W-1:0];
                end
                REG_SCENE_MOTION_PERCENT:
                begin
                    cfg_reg.scene_motion_percent <= cfg_data[PERCENT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    scd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .q_count   (q_count),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    scd_fifo
    #(
        .WIDTH ($bits(row_item_t)),
        .DEPTH (ROW_QUEUE_DEPTH)
    )
    u_row_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .count   (q_count)
    );

    scd_back
    #(
        .MAX_FRAME_BLOCKS (MAX_FRAME_BLOCKS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_count     (q_count),
        .q_rd_data   (q_rd_data),
        .q_rd_en     (q_rd_en),
        .out_count   (out_count),
        .out_wr_en   (out_wr_en),
        .out_wr_data (out_wr_data)
    );

    // result transfer pops the oldest frame result
    assign empty     = (out_count == '0);
    assign out_rd_en = pop && !empty;

    scd_fifo
    #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (RESULT_QUEUE_DEPTH)
    )
    u_result_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr_en),
        .wr_data (out_wr_data),
        .rd_en   (out_rd_en),
        .rd_data (result),
        .count   (out_count)
    );

endmodule
